// ===== rtl/core/mspfr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mspfr_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned PhaseW = 3;

  // parser phases
  localparam logic [PhaseW-1:0] PhIdle    = 3'd0;
  localparam logic [PhaseW-1:0] PhDollar  = 3'd1;
  localparam logic [PhaseW-1:0] PhM       = 3'd2;
  localparam logic [PhaseW-1:0] PhDir     = 3'd3;
  localparam logic [PhaseW-1:0] PhLen     = 3'd4;
  localparam logic [PhaseW-1:0] PhPayload = 3'd5;
  localparam logic [PhaseW-1:0] PhCheck   = 3'd6;

  localparam logic [ByteW-1:0] ChDollar = 8'h24;
  localparam logic [ByteW-1:0] ChM      = 8'h4D;
  localparam logic [ByteW-1:0] ChArrow  = 8'h3E;

  // result kinds
  localparam logic KindPayload = 1'b0;
  localparam logic KindEof     = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [ByteW-1:0] cmd_id;
    logic [ByteW-1:0] data_byte;
    logic [ByteW-1:0] byte_index;
    logic [ByteW-1:0] frame_len;
    logic             checksum_ok;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/mspfr_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface mspfr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface mspfr_result_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] cmd_id;
  logic [7:0] data_byte;
  logic [7:0] byte_index;
  logic [7:0] frame_len;
  logic       checksum_ok;

  modport source (
    output valid, output kind, output cmd_id, output data_byte,
    output byte_index, output frame_len, output checksum_ok, input ready
  );
  modport sink (
    input valid, input kind, input cmd_id, input data_byte,
    input byte_index, input frame_len, input checksum_ok, output ready
  );
endinterface

interface mspfr_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] direction_char;

  modport source (output valid, output direction_char, input ready);
  modport sink (input valid, input direction_char, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/mspfr_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mspfr_parser
  import mspfr_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire logic [ByteW-1:0] byte_i,
  input  wire logic [ByteW-1:0] direction_char_i,
  output      logic             res_valid_o,
  output      result_t          res_o
);

  logic [PhaseW-1:0] phase_q, phase_d;
  logic [ByteW-1:0]  len_q, len_d;
  logic [ByteW-1:0]  cnt_q, cnt_d;
  logic [ByteW-1:0]  cmd_q, cmd_d;
  logic [ByteW-1:0]  xor_q, xor_d;
  logic [ByteW-1:0]  cnt_inc;

  assign cnt_inc = cnt_q + 8'd1;

  always_comb begin
    phase_d     = phase_q;
    len_d       = len_q;
    cnt_d       = cnt_q;
    cmd_d       = cmd_q;
    xor_d       = xor_q;
    res_valid_o = 1'b0;
    res_o       = '{kind: KindPayload, cmd_id: cmd_q, data_byte: byte_i,
                    byte_index: cnt_q, frame_len: len_q, checksum_ok: 1'b0};
    unique case (phase_q)
      PhDollar: begin
        phase_d = (byte_i == ChM) ? PhM : PhIdle;
      end
      PhM: begin
        phase_d = (byte_i == direction_char_i) ? PhDir : PhIdle;
      end
      PhDir: begin
        len_d   = byte_i;
        xor_d   = byte_i;
        phase_d = PhLen;
      end
      PhLen: begin
        cmd_d   = byte_i;
        xor_d   = xor_q ^ byte_i;
        phase_d = (len_q == '0) ? PhCheck : PhPayload;
      end
      PhPayload: begin
        res_valid_o = 1'b1;
        xor_d       = xor_q ^ byte_i;
        cnt_d       = cnt_inc;
        if (cnt_inc >= len_q) begin
          phase_d = PhCheck;
        end
      end
      PhCheck: begin
        res_valid_o       = 1'b1;
        res_o.kind        = KindEof;
        res_o.data_byte   = '0;
        res_o.byte_index  = '0;
        res_o.checksum_ok = (byte_i == xor_q);
        phase_d           = PhIdle;
      end
      default: begin
        len_d   = '0;
        cnt_d   = '0;
        cmd_d   = '0;
        xor_d   = '0;
        phase_d = (byte_i == ChDollar) ? PhDollar : PhIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      len_q   <= '0;
      cnt_q   <= '0;
      cmd_q   <= '0;
      xor_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      cmd_q   <= cmd_d;
      xor_q   <= xor_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/msp_frame_receiver.sv =====
// msp v1 frame receiver
// byte_i: one received serial byte per transfer. Frames are '$', 'M',
// direction byte, length, command, payload bytes and an xor checksum byte.
// result_o: one transfer per payload byte (kind 0, with command, byte and
// index) and one per checksum byte (kind 1, with length and checksum_ok).
// Header bytes and bytes between frames produce no result.
// cfg_i: writes the expected direction byte, reset value '>'; it is always
// ready and is to be written only while no frame is in flight.
// Result path: each byte passes through the input register, the combinational
// parser and then the output register.
// Throughput: one byte per cycle unless the result sink stalls; the parser
// state updates once per byte. Reset returns the parser to idle, empties
// both registers and restores the direction byte.
// When the result sink stalls, the output register holds its transfer, the
// input register holds its byte, and byte_i.ready is low while both are full.
`timescale 1ns / 1ps
`default_nettype none

module msp_frame_receiver
  import mspfr_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  mspfr_cfg_if.sink      cfg_i,
  mspfr_byte_if.sink     byte_i,
  mspfr_result_if.source result_o
);

  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;
  logic [ByteW-1:0] dir_q;
  logic             out_valid_q;
  result_t          out_q;
  logic             advance;
  logic             in_ready;
  logic             res_valid;
  result_t          res;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= ChArrow;
    end else if (cfg_i.valid) begin
      dir_q <= cfg_i.direction_char;
    end
  end

  assign advance      = !out_valid_q || result_o.ready;
  assign in_ready     = !in_valid_q || advance;
  assign byte_i.ready = in_ready;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= byte_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && byte_i.valid) begin
      in_byte_q <= byte_i.rx_byte;
    end
  end

  mspfr_parser u_parser (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (in_valid_q && advance),
    .byte_i           (in_byte_q),
    .direction_char_i (dir_q),
    .res_valid_o      (res_valid),
    .res_o            (res)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q && res_valid) begin
      out_q <= res;
    end
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.kind        = out_q.kind;
  assign result_o.cmd_id      = out_q.cmd_id;
  assign result_o.data_byte   = out_q.data_byte;
  assign result_o.byte_index  = out_q.byte_index;
  assign result_o.frame_len   = out_q.frame_len;
  assign result_o.checksum_ok = out_q.checksum_ok;

`ifndef SYNTHESIS
  a_ready_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !byte_i.ready |-> (in_valid_q && out_valid_q && !result_o.ready))
    else $error("input stalled without an output stall");

  a_eof_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.kind == KindEof) |->
      (out_q.data_byte == '0 && out_q.byte_index == '0))
    else $error("end of frame carries payload fields");

  a_payload_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.kind == KindPayload) |->
      (!out_q.checksum_ok && out_q.byte_index < out_q.frame_len))
    else $error("payload result out of frame bounds");
`endif

endmodule

`default_nettype wire
